// ----- hdl/swmc_pkg.sv -----
// shared types and constants for the sliding window median cost block
`default_nettype none
package swmc_pkg;
  localparam int unsigned WinMax     = 256;
  localparam int unsigned IdxBits    = 8;
  localparam int unsigned CntBits    = 9;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned SumBits    = 41;
  localparam int unsigned CostBits   = 40;

  typedef logic [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic    clear;
    logic    ins;
    logic    evict;
    sample_t key;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- hdl/swmc_ring.sv -----
// arrival-order sample memory, one write and one registered read port
`default_nettype none
module swmc_ring (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [swmc_pkg::IdxBits-1:0]  waddr_i,
  input  swmc_pkg::sample_t             wdata_i,
  input  logic [swmc_pkg::IdxBits-1:0]  raddr_i,
  output swmc_pkg::sample_t             rdata_o
);
  import swmc_pkg::*;

  sample_t mem_q [WinMax];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- hdl/swmc_cell.sv -----
// one sorted cell: shifts right on insert, left on evict
`default_nettype none
module swmc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swmc_pkg::cell_ctrl_t  ctrl_i,
  input  swmc_pkg::sample_t     left_val_i,
  input  logic                  left_vld_i,
  input  logic                  left_gt_i,
  input  swmc_pkg::sample_t     right_val_i,
  input  logic                  right_vld_i,
  output swmc_pkg::sample_t     val_o,
  output logic                  vld_o,
  output logic                  gt_o
);
  import swmc_pkg::*;

  sample_t val_q, val_d;
  logic    vld_q, vld_d;
  logic    ge;

  assign gt_o = !vld_q || (val_q > ctrl_i.key);
  assign ge   = vld_q && (val_q >= ctrl_i.key);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else begin
        val_d = ctrl_i.key;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.evict && ge) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
endmodule
`default_nettype wire

// ----- hdl/sliding_window_median_cost_core.sv -----
// top level: sequencer, running sums, sorted cell chain and ring memory
//
// The sequencer evicts oldest samples through a registered ring read while the
// window holds at least window_size of them (one with a full window), then
// inserts the new one into the sorted chain of 256 cells. A result, when the
// window is full, goes to an output register that holds it while out_stall_i is
// high. The next result waits for that register, and in_stall_o stays high
// meanwhile. Zero in window_size acts as one, above 256 as 256.
`default_nettype none
module sliding_window_median_cost_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_i,
  input  logic        stream_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [39:0] window_cost_o,
  output logic [31:0] window_median_o
);
  import swmc_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StChk  = 3'd1;
  localparam logic [2:0] StEvt  = 3'd2;
  localparam logic [2:0] StIns  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CntBits-1:0] wsize_q, k;
  logic [CntBits-1:0] cnt_q, cnt_d, ln;
  logic [IdxBits-1:0] head_q, head_d;
  logic [SumBits-1:0] lsum_q, lsum_d, ssum_q, ssum_d;
  sample_t            smp_q, smp_d, ring_rd, lo_val, hi_val;
  logic               out_vld_q;
  logic [CostBits-1:0] cost_q;
  sample_t            med_q;
  logic [SumBits-1:0] cost_full;
  cell_ctrl_t         ctrl;
  logic               accept;

  sample_t val  [WinMax];
  logic    vld  [WinMax];
  logic    gt   [WinMax];

  assign k = (wsize_q == '0) ? CntBits'(1) :
             (wsize_q > CntBits'(WinMax)) ? CntBits'(WinMax) : wsize_q;
  assign ln = CntBits'((cnt_q + CntBits'(1)) >> 1);

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WinMax; i++) begin
      if (CntBits'(i) == ln - CntBits'(1)) lo_val = lo_val | val[i];
      if (CntBits'(i) == ln) hi_val = hi_val | val[i];
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  swmc_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == StIns),
    .waddr_i (head_q),
    .wdata_i (smp_q),
    .raddr_i (head_q - cnt_q[IdxBits-1:0]),
    .rdata_o (ring_rd)
  );

  always_comb begin
    ctrl.clear = accept && stream_start_i;
    ctrl.ins   = (state_q == StIns);
    ctrl.evict = (state_q == StEvt);
    ctrl.key   = (state_q == StEvt) ? ring_rd : smp_q;
  end

  for (genvar g = 0; g < WinMax; g++) begin : g_cell
    if (g == 0) begin : g_first
      swmc_cell u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl),
        .left_val_i ('0), .left_vld_i (1'b0), .left_gt_i (1'b0),
        .right_val_i (val[g+1]), .right_vld_i (vld[g+1]),
        .val_o (val[g]), .vld_o (vld[g]), .gt_o (gt[g])
      );
    end else if (g == WinMax-1) begin : g_last
      swmc_cell u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl),
        .left_val_i (val[g-1]), .left_vld_i (vld[g-1]), .left_gt_i (gt[g-1]),
        .right_val_i ('0), .right_vld_i (1'b0),
        .val_o (val[g]), .vld_o (vld[g]), .gt_o (gt[g])
      );
    end else begin : g_mid
      swmc_cell u_cell (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ctrl),
        .left_val_i (val[g-1]), .left_vld_i (vld[g-1]), .left_gt_i (gt[g-1]),
        .right_val_i (val[g+1]), .right_vld_i (vld[g+1]),
        .val_o (val[g]), .vld_o (vld[g]), .gt_o (gt[g])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    lsum_d  = lsum_q;
    ssum_d  = ssum_q;
    smp_d   = smp_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          smp_d   = sample_i;
          state_d = StChk;
          if (stream_start_i) begin
            cnt_d  = '0;
            head_d = '0;
            lsum_d = '0;
            ssum_d = '0;
          end
        end
      end
      StChk: begin
        state_d = (cnt_q >= k) ? StEvt : StIns;
      end
      StEvt: begin
        ssum_d = ssum_q - SumBits'(ring_rd);
        if (cnt_q[0]) begin
          lsum_d = (lo_val >= ring_rd) ? lsum_q - SumBits'(ring_rd)
                                       : lsum_q - SumBits'(lo_val);
        end else if (lo_val >= ring_rd) begin
          lsum_d = lsum_q - SumBits'(ring_rd) + SumBits'(hi_val);
        end
        cnt_d   = cnt_q - CntBits'(1);
        state_d = StChk;
      end
      StIns: begin
        ssum_d = ssum_q + SumBits'(smp_q);
        if (!cnt_q[0]) begin
          lsum_d = (cnt_q == '0 || hi_val > smp_q) ? lsum_q + SumBits'(smp_q)
                                                   : lsum_q + SumBits'(hi_val);
        end else if (lo_val > smp_q) begin
          lsum_d = lsum_q + SumBits'(smp_q) - SumBits'(lo_val);
        end
        cnt_d   = cnt_q + CntBits'(1);
        head_d  = head_q + IdxBits'(1);
        state_d = (cnt_q + CntBits'(1) == k) ? StFin : StIdle;
      end
      StFin: begin
        if (!(out_vld_q && out_stall_i)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign cost_full = ssum_q - (lsum_q << 1) + (cnt_q[0] ? SumBits'(lo_val) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wsize_q   <= CntBits'(1);
      cnt_q     <= '0;
      head_q    <= '0;
      lsum_q    <= '0;
      ssum_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      lsum_q  <= lsum_d;
      ssum_q  <= ssum_d;
      if (cfg_we_i) wsize_q <= cfg_wdata_i;
      if (state_q == StFin && !(out_vld_q && out_stall_i)) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    if (state_q == StFin && !(out_vld_q && out_stall_i)) begin
      cost_q <= cost_full[CostBits-1:0];
      med_q  <= lo_val;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign window_cost_o   = cost_q;
  assign window_median_o = med_q;
endmodule
`default_nettype wire
